@@ src/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo position controller package
// Shared types, register codes, keypad codes and the entry saturation helper.
// ----------------------------------------------------------------------------
package spc_pkg;

   // Register file layout: two 8-bit registers at byte addresses 0 and 4.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic REG_GAIN       = 1'b0;
   localparam logic REG_DUTY_LIMIT = 1'b1;

   localparam logic [7:0] GAIN_RESET       = 8'd10;
   localparam logic [7:0] DUTY_LIMIT_RESET = 8'd116;

   // Keypad scan codes.
   localparam logic [3:0] KEY_NONE   = 4'h0;
   localparam logic [3:0] KEY_ENTER  = 4'hA;
   localparam logic [3:0] KEY_ZERO   = 4'hB;
   localparam logic [3:0] KEY_NEGATE = 4'hC;

   // Encoder phase codes that mark a count step.
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;
   localparam logic [1:0] PHASE_THREE = 2'd3;

   // Largest magnitude of the typed entry.
   localparam logic signed [19:0] ENTRY_MAX = 20'sd32766;

   // Input item.
   typedef struct packed {
      logic [1:0] encoder_phase;
      logic [3:0] key_code;
   } req_type;

   // Result item.
   typedef struct packed {
      logic              direction;
      logic [7:0]        duty;
      logic signed [15:0] position_now;
      logic signed [15:0] reference_now;
      logic signed [15:0] entry_now;
   } rsp_type;

   // Saturate a widened entry value to plus or minus the entry limit.
   function automatic logic signed [15:0] sat_entry(input logic signed [19:0] v);
      logic signed [19:0] r;
      begin
         if (v > ENTRY_MAX) begin
            r = ENTRY_MAX;
         end else if (v < -ENTRY_MAX) begin
            r = -ENTRY_MAX;
         end else begin
            r = v;
         end
         return r[15:0];
      end
   endfunction

endpackage

@@ src/servo_position_p_controller.sv @@
// ----------------------------------------------------------------------------
// Servo position proportional controller
// Quadrature position counter, decimal keypad entry of the target position
// and a clamped proportional drive given as direction and magnitude.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while req_stall is low: every input
// item is worked through in combinational logic between the state registers
// and the result register, so throughput is one item per cycle unless stalled.
// A two-entry output stage (result register plus skid register) keeps input
// transfers going while a result is held by rsp_stall; req_stall rises only
// once both entries are occupied. The drive of each result uses the position
// error left by the previous item, so a new target or position shows in the
// drive one item later. The user must write registers gain and duty_limit over
// the csr_ port only while no item is in flight; the block does not enforce it.
module servo_position_p_controller (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  spc_pkg::req_type                   req_data,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output spc_pkg::rsp_type                   rsp_data,
   // Configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import spc_pkg::*;

   // Configuration registers
   logic [7:0] gain_ff;
   logic [7:0] duty_limit_ff;
   logic       csr_write;

   // Controller state
   logic [1:0]         last_phase_ff, last_phase_in;
   logic [15:0]        position_ff, position_in;
   logic signed [15:0] target_ff, target_in;
   logic signed [15:0] typed_ff, typed_in;
   logic [3:0]         previous_key_ff, previous_key_in;
   logic signed [16:0] previous_error_ff, previous_error_in;

   // Output stage
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   rsp_type result_in;

   // Datapath intermediates
   logic               accept;
   logic               pop;
   logic [3:0]         key;
   logic signed [19:0] typed_wide;
   logic signed [19:0] entry_scaled;
   logic signed [19:0] entry_negated;
   logic signed [25:0] product;
   logic signed [25:0] product_neg;
   logic signed [25:0] limit_wide;
   logic [7:0]         duty_in;
   logic               direction_in;

   // Handshakes
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration port: always ready, register chosen by the word address bit.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_GAIN:       csr_prdata = {24'd0, gain_ff};
         REG_DUTY_LIMIT: csr_prdata = {24'd0, duty_limit_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_RESET;
         duty_limit_ff <= DUTY_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_GAIN:       gain_ff       <= csr_pwdata[7:0];
            REG_DUTY_LIMIT: duty_limit_ff <= csr_pwdata[7:0];
            default:        gain_ff       <= gain_ff;
         endcase
      end
   end

   // Key codes beyond negate count as no key.
   assign key = (req_data.key_code > KEY_NEGATE) ? KEY_NONE : req_data.key_code;

   // Encoder step: up on phase three then one, down on phase two then three.
   always_comb begin
      position_in = position_ff;
      if (req_data.encoder_phase == PHASE_ONE && last_phase_ff == PHASE_THREE) begin
         position_in = position_ff + 16'd1;
      end else if (req_data.encoder_phase == PHASE_THREE &&
                   last_phase_ff == PHASE_TWO) begin
         position_in = position_ff - 16'd1;
      end
      last_phase_in = req_data.encoder_phase;
   end

   // Keypad entry: the held key acts once it is released.
   assign typed_wide    = {{4{typed_ff[15]}}, typed_ff};
   assign entry_scaled  = (typed_wide <<< 3) + (typed_wide <<< 1) +
                          ((previous_key_ff == KEY_ZERO) ? 20'sd0 :
                           $signed({16'd0, previous_key_ff}));
   assign entry_negated = -typed_wide;

   always_comb begin
      target_in = target_ff;
      typed_in  = typed_ff;
      if (previous_key_ff != KEY_NONE && key == KEY_NONE) begin
         case (previous_key_ff)
            KEY_ENTER: begin
               target_in = typed_ff;
               typed_in  = 16'sd0;
            end
            KEY_NEGATE: begin
               typed_in = sat_entry(entry_negated);
            end
            default: begin
               typed_in = sat_entry(entry_scaled);
            end
         endcase
      end
      previous_key_in = key;
   end

   // Error for the next item, from the updated position and target.
   assign previous_error_in = $signed({position_in[15], position_in}) -
                              $signed({target_in[15], target_in});

   // Proportional drive from the stored error, clamped to the duty limit.
   assign product     = $signed({18'd0, gain_ff}) *
                        $signed({{9{previous_error_ff[16]}}, previous_error_ff});
   assign product_neg = -product;
   assign limit_wide  = $signed({18'd0, duty_limit_ff});

   always_comb begin
      if (product > limit_wide || product < -limit_wide) begin
         duty_in = duty_limit_ff;
      end else if (product[25]) begin
         duty_in = product_neg[7:0];
      end else begin
         duty_in = product[7:0];
      end
      // A negative drive clamped to a zero limit becomes zero, hence forward.
      direction_in = product[25] && (duty_in != 8'd0);
   end

   always_comb begin
      result_in.direction     = direction_in;
      result_in.duty          = duty_in;
      result_in.position_now  = $signed(position_in);
      result_in.reference_now = target_in;
      result_in.entry_now     = typed_in;
   end

   // State update on every input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff     <= 2'd0;
         position_ff       <= 16'd0;
         target_ff         <= 16'sd0;
         typed_ff          <= 16'sd0;
         previous_key_ff   <= KEY_NONE;
         previous_error_ff <= 17'sd0;
      end else if (accept) begin
         last_phase_ff     <= last_phase_in;
         position_ff       <= position_in;
         target_ff         <= target_in;
         typed_ff          <= typed_in;
         previous_key_ff   <= previous_key_in;
         previous_error_ff <= previous_error_in;
      end
   end

   // Output stage control: result register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output stage payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= result_in;
         end else begin
            out_data_ff <= result_in;
         end
      end
   end

   // The skid entry is only ever filled behind a held result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while result register is empty");

   // The drive magnitude never exceeds the duty limit.
   a_duty_limited: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.duty <= duty_limit_ff))
      else $error("duty above duty limit");

   // Reverse direction always comes with a nonzero drive.
   a_reverse_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.direction) |-> (out_data_ff.duty != 8'd0))
      else $error("reverse direction with zero duty");

   // The typed entry stays within its saturation range.
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($signed(out_data_ff.entry_now) <= 16'sd32766 &&
                        $signed(out_data_ff.entry_now) >= -16'sd32766))
      else $error("typed entry outside saturation range");

   // A result register that is held keeps its result.
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("held result changed");

endmodule
